### hdl/ps2mct_pkg.sv
package ps2mct_pkg;

  // fixed field widths
  localparam int unsigned POS_W   = 12;
  localparam int unsigned BOUND_W = 13;
  localparam int unsigned GEN_W   = 32;
  localparam int unsigned WHEEL_W = 16;

  // reset values
  localparam int unsigned WIDTH_RST  = 320;
  localparam int unsigned HEIGHT_RST = 200;
  localparam int unsigned CUR_X_RST  = 160;
  localparam int unsigned CUR_Y_RST  = 100;

  // byte 0 sync bit and button bits
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned BTN_LEFT   = 0;
  localparam int unsigned BTN_RIGHT  = 1;
  localparam int unsigned BTN_MIDDLE = 2;

  typedef enum logic [1:0] {
    OP_DATA     = 2'd0,
    OP_WHEEL    = 2'd1,
    OP_CLICK    = 2'd2,
    OP_RECENTER = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WHEEL  = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]          pos_x;
    logic [POS_W-1:0]          pos_y;
    logic                      left_down;
    logic                      right_down;
    logic                      middle_down;
    logic [GEN_W-1:0]          update_count;
    logic signed [WHEEL_W-1:0] wheel_total;
    logic                      click_valid;
    logic [POS_W-1:0]          click_pos_x;
    logic [POS_W-1:0]          click_pos_y;
    logic                      packet_done;
  } out_item_t;

endpackage

### hdl/ps2mct_axis.sv
module ps2mct_axis #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]           cur_i,
  input  logic signed [8:0]               delta_i,
  input  logic [ps2mct_pkg::BOUND_W-1:0]  bound_i,
  output logic [COORD_BITS-1:0]           moved_o,
  output logic [COORD_BITS-1:0]           center_o
);

  localparam int unsigned EW = (COORD_BITS + 1 > ps2mct_pkg::BOUND_W) ?
                               COORD_BITS + 1 : ps2mct_pkg::BOUND_W;
  localparam int unsigned SW = EW + 1;

  logic [EW-1:0]        bound_ext;
  logic [EW-1:0]        lim;
  logic [EW-1:0]        eff;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] eff_s;

  // bound limited to the coordinate range (never zero, as the tracker drops zero bounds)
  assign bound_ext = EW'(bound_i);
  assign lim       = EW'(1) << COORD_BITS;
  assign eff       = (bound_ext > lim) ? lim : bound_ext;
  assign eff_s     = $signed({1'b0, eff});

  assign sum = $signed({1'b0, EW'(cur_i)}) + SW'(delta_i);

  always_comb begin
    if (sum[SW-1]) begin
      moved_o = '0;
    end else if (sum >= eff_s) begin
      moved_o = COORD_BITS'(eff - EW'(1));
    end else begin
      moved_o = COORD_BITS'(sum);
    end
  end

  assign center_o = COORD_BITS'(eff >> 1);

endmodule

### hdl/ps2_mouse_packet_cursor_tracker.sv
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+--------------------------------
// in      | input     | in_valid_i / in_ready_o    | in_item_i  (op, data_byte)
// out     | output    | out_valid_o / out_ready_i  | out_item_o (cursor, buttons, ...)
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one item a cycle sustained while the result is taken; an accepted item passes the input
// register, then state update and result register
// state and result are written in the same cycle, so the next item sees it directly
// reset clears all control state, bounds to 320 x 200 and the cursor to 160,100
// a stalled result holds the output register; the input register still takes one
// more item, then in_ready_o drops until the result moves
// cfg writes are taken in any cycle; senders issue them only while no item is in flight
module ps2_mouse_packet_cursor_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ps2mct_pkg::in_item_t          in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ps2mct_pkg::out_item_t         out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [ps2mct_pkg::BOUND_W-1:0] cfg_data_i
);

  localparam int unsigned BW = ps2mct_pkg::BOUND_W;
  localparam int unsigned PW = ps2mct_pkg::POS_W;
  localparam int unsigned WW = ps2mct_pkg::WHEEL_W;

  // configuration registers
  logic [BW-1:0] width_q, height_q;
  logic          wheel_mode_q;

  // input stage
  logic                 s1_valid_q;
  ps2mct_pkg::in_item_t s1_item_q;

  // block state
  logic [1:0]            byte_count_q, byte_count_d;
  logic [7:0]            held_q [3];
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [2:0]            buttons_q, buttons_d;
  logic signed [WW-1:0]  wheel_q, wheel_d;
  logic                  click_pend_q, click_pend_d;
  logic [COORD_BITS-1:0] click_x_q, click_x_d, click_y_q, click_y_d;
  logic [31:0]           gen_q, gen_d;

  // result stage
  logic                  out_valid_q;
  ps2mct_pkg::out_item_t out_q, out_d;

  logic advance;

  // pipeline control: a result register that is free or emptying lets stage 1 move
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // config writes, zero bounds are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= BW'(ps2mct_pkg::WIDTH_RST);
      height_q     <= BW'(ps2mct_pkg::HEIGHT_RST);
      wheel_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (ps2mct_pkg::cfg_idx_e'(cfg_index_i))
        ps2mct_pkg::CFG_WIDTH: begin
          if (cfg_data_i != '0) width_q <= cfg_data_i;
        end
        ps2mct_pkg::CFG_HEIGHT: begin
          if (cfg_data_i != '0) height_q <= cfg_data_i;
        end
        ps2mct_pkg::CFG_WHEEL: wheel_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // held packet bytes; the third byte bypasses the store when it completes a packet
  logic [7:0] b0, b1, b2;
  logic       is_data, in_sync, completes, store_byte;

  assign is_data    = (s1_item_q.op == ps2mct_pkg::OP_DATA);
  assign in_sync    = !(byte_count_q == 2'd0 && !s1_item_q.data_byte[ps2mct_pkg::SYNC_BIT]);
  // size 3 completes at count 2 (or at 3 after a mode change), size 4 at count 3
  assign completes  = is_data && in_sync &&
                      (wheel_mode_q ? (byte_count_q == 2'd3)
                                    : (byte_count_q == 2'd2 || byte_count_q == 2'd3));
  assign store_byte = is_data && in_sync && (byte_count_q != 2'd3);

  assign b0 = held_q[0];
  assign b1 = held_q[1];
  assign b2 = (byte_count_q == 2'd2) ? s1_item_q.data_byte : held_q[2];

  // per-axis movement and recenter
  logic signed [8:0]     dx, dy;
  logic [COORD_BITS-1:0] moved_x, moved_y, center_x, center_y;

  assign dx = $signed({b1[7], b1});
  assign dy = -$signed({b2[7], b2});

  ps2mct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .cur_i    (cur_x_q),
    .delta_i  (dx),
    .bound_i  (width_q),
    .moved_o  (moved_x),
    .center_o (center_x)
  );

  ps2mct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .cur_i    (cur_y_q),
    .delta_i  (dy),
    .bound_i  (height_q),
    .moved_o  (moved_y),
    .center_o (center_y)
  );

  // wheel nibble, sign-extended and saturated into the accumulator
  logic signed [3:0]    wstep;
  logic signed [WW:0]   wsum;
  logic signed [WW-1:0] wsat;

  assign wstep = $signed(s1_item_q.data_byte[3:0]);
  assign wsum  = $signed({wheel_q[WW-1], wheel_q}) + (WW + 1)'(wstep);

  always_comb begin
    if (wsum[WW] != wsum[WW-1]) begin
      wsat = wsum[WW] ? {1'b1, {(WW - 1){1'b0}}} : {1'b0, {(WW - 1){1'b1}}};
    end else begin
      wsat = wsum[WW-1:0];
    end
  end

  // next state and result
  always_comb begin
    logic [1:0] gen_inc;
    logic       released;
    gen_inc      = 2'd0;
    released     = 1'b0;
    byte_count_d = byte_count_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    buttons_d    = buttons_q;
    wheel_d      = wheel_q;
    click_pend_d = click_pend_q;
    click_x_d    = click_x_q;
    click_y_d    = click_y_q;

    out_d             = '0;
    out_d.wheel_total = wheel_q;

    unique case (s1_item_q.op)
      ps2mct_pkg::OP_DATA: begin
        if (completes) begin
          byte_count_d = 2'd0;
          buttons_d    = b0[2:0];
          cur_x_d      = moved_x;
          cur_y_d      = moved_y;
          gen_inc      = 2'd1;
          if (wheel_mode_q && wstep != 4'sd0) begin
            wheel_d = wsat;
            gen_inc = gen_inc + 2'd1;
          end
          released = buttons_q[ps2mct_pkg::BTN_LEFT] && !b0[ps2mct_pkg::BTN_LEFT];
          if (released) begin
            click_pend_d = 1'b1;
            click_x_d    = moved_x;
            click_y_d    = moved_y;
            gen_inc      = gen_inc + 2'd1;
          end
        end else if (in_sync) begin
          byte_count_d = byte_count_q + 2'd1;
        end
        out_d.wheel_total = wheel_d;
        out_d.packet_done = completes;
      end
      ps2mct_pkg::OP_WHEEL: begin
        wheel_d = '0;
      end
      ps2mct_pkg::OP_CLICK: begin
        if (click_pend_q) begin
          click_pend_d      = 1'b0;
          out_d.click_valid = 1'b1;
          out_d.click_pos_x = PW'(click_x_q);
          out_d.click_pos_y = PW'(click_y_q);
        end
      end
      ps2mct_pkg::OP_RECENTER: begin
        cur_x_d = center_x;
        cur_y_d = center_y;
        gen_inc = 2'd1;
      end
      default: ;
    endcase

    gen_d = gen_q + 32'(gen_inc);

    out_d.pos_x        = PW'(cur_x_d);
    out_d.pos_y        = PW'(cur_y_d);
    out_d.left_down    = buttons_d[ps2mct_pkg::BTN_LEFT];
    out_d.right_down   = buttons_d[ps2mct_pkg::BTN_RIGHT];
    out_d.middle_down  = buttons_d[ps2mct_pkg::BTN_MIDDLE];
    out_d.update_count = gen_d;
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      byte_count_q <= '0;
      cur_x_q      <= COORD_BITS'(ps2mct_pkg::CUR_X_RST);
      cur_y_q      <= COORD_BITS'(ps2mct_pkg::CUR_Y_RST);
      buttons_q    <= '0;
      wheel_q      <= '0;
      click_pend_q <= 1'b0;
      click_x_q    <= '0;
      click_y_q    <= '0;
      gen_q        <= '0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q  <= 1'b1;
        byte_count_q <= byte_count_d;
        cur_x_q      <= cur_x_d;
        cur_y_q      <= cur_y_d;
        buttons_q    <= buttons_d;
        wheel_q      <= wheel_d;
        click_pend_q <= click_pend_d;
        click_x_q    <= click_x_d;
        click_y_q    <= click_y_d;
        gen_q        <= gen_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_item_q <= in_item_i;
    if (advance) out_q <= out_d;
    if (advance && store_byte) held_q[byte_count_q] <= s1_item_q.data_byte;
  end

  // checks
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("stalled input stage lost its item");

  a_click_only_on_consume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_item_q.op != ps2mct_pkg::OP_CLICK) |=> !out_q.click_valid)
    else $error("click reported on an item that does not consume clicks");

  a_wheel_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_item_q.op == ps2mct_pkg::OP_WHEEL) |=> (wheel_q == '0))
    else $error("wheel total not cleared by consume");

  // a count of three is only left over from wheel mode, never built in three-byte mode
  a_count_three_needs_wheel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !wheel_mode_q && byte_count_q != 2'd3) |=> (byte_count_q != 2'd3))
    else $error("four bytes held in three-byte mode");

endmodule

### dv/ps2_mouse_packet_cursor_tracker_tb.sv
module ps2_mouse_packet_cursor_tracker_tb;

  localparam int COORD_LIMIT = 1 << ps2mct_pkg::POS_W;
  localparam int WHEEL_MAX   = 32767;
  localparam int WHEEL_MIN   = -32768;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // block inputs, all known from time zero
  logic                             in_valid  = 1'b0;
  ps2mct_pkg::in_item_t             in_item   = '0;
  logic                             out_ready = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic [1:0]                       cfg_index = ps2mct_pkg::CFG_NONE;
  logic [ps2mct_pkg::BOUND_W-1:0]   cfg_data  = '0;

  // block outputs
  logic                  in_ready_o;
  logic                  out_valid_o;
  ps2mct_pkg::out_item_t out_item_o;
  logic                  cfg_ready_o;

  ps2_mouse_packet_cursor_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // items waiting for the driver, filled by the sequencer on falling edges
  ps2mct_pkg::in_item_t queued_items[$];

  // expected reports: ring written by the driver at acceptance, read by the monitor
  // counters move by nonblocking assignment so both sides see pre-edge values
  ps2mct_pkg::out_item_t expected_ring [0:255];
  int unsigned made    = 0;
  int unsigned checked = 0;

  int  error_count = 0;
  bit  steady      = 1'b0;  // no idling on either side while set
  bit  heading     = 1'b1;  // drift direction of large random moves

  // tracker copy of the configuration
  int unsigned width_reg  = ps2mct_pkg::WIDTH_RST;
  int unsigned height_reg = ps2mct_pkg::HEIGHT_RST;
  bit          wheel_on   = 1'b0;

  // tracker copy of the block state
  int         byte_idx   = 0;
  logic [7:0] held [3];
  int         cur_x      = ps2mct_pkg::CUR_X_RST;
  int         cur_y      = ps2mct_pkg::CUR_Y_RST;
  logic [2:0] buttons    = '0;
  int         wheel_acc  = 0;
  bit         click_pend = 1'b0;
  int         click_x    = 0;
  int         click_y    = 0;
  logic [ps2mct_pkg::GEN_W-1:0] gen = '0;

  // -------------------------------------------------------------------------
  // cursor tracker prediction
  // -------------------------------------------------------------------------

  // zero bound acts as one, anything past the coordinate range is capped
  function automatic int bound_of(int unsigned b);
    if (b > COORD_LIMIT) return COORD_LIMIT;
    if (b == 0) return 1;
    return int'(b);
  endfunction

  function automatic int clamp_to(int v, int lim);
    if (v < 0) v = 0;
    if (v >= lim) v = lim - 1;
    return v;
  endfunction

  // buttons from byte 0, move by dx and minus dy, wheel step, click on left release
  function automatic void complete_packet(logic [7:0] last_byte);
    bit left_before;
    int step;
    left_before = buttons[ps2mct_pkg::BTN_LEFT];
    buttons     = held[0][2:0];
    cur_x = clamp_to(cur_x + int'($signed(held[1])), bound_of(width_reg));
    cur_y = clamp_to(cur_y - int'($signed(held[2])), bound_of(height_reg));
    gen++;
    if (wheel_on) begin
      step = int'($signed(last_byte[3:0]));
      if (step != 0) begin
        wheel_acc = wheel_acc + step;
        if (wheel_acc > WHEEL_MAX) wheel_acc = WHEEL_MAX;
        if (wheel_acc < WHEEL_MIN) wheel_acc = WHEEL_MIN;
        gen++;
      end
    end
    if (left_before && !buttons[ps2mct_pkg::BTN_LEFT]) begin
      click_pend = 1'b1;
      click_x    = cur_x;
      click_y    = cur_y;
      gen++;
    end
  endfunction

  function automatic ps2mct_pkg::out_item_t track_item(ps2mct_pkg::in_item_t it);
    ps2mct_pkg::out_item_t r;
    int                    wheel_seen;
    int                    packet_len;
    r = '0;
    wheel_seen = wheel_acc;
    case (it.op)
      ps2mct_pkg::OP_DATA: begin
        // a first byte without the sync bit is dropped
        if (byte_idx != 0 || it.data_byte[ps2mct_pkg::SYNC_BIT]) begin
          packet_len = wheel_on ? 4 : 3;
          if (byte_idx < 3) held[byte_idx] = it.data_byte;
          // a mode change can leave the count already at the packet size
          if (byte_idx + 1 >= packet_len) begin
            byte_idx = 0;
            complete_packet(it.data_byte);
            r.packet_done = 1'b1;
          end else begin
            byte_idx++;
          end
        end
        wheel_seen = wheel_acc;
      end
      ps2mct_pkg::OP_WHEEL: begin
        // report the total before clearing it
        wheel_acc = 0;
      end
      ps2mct_pkg::OP_CLICK: begin
        if (click_pend) begin
          click_pend      = 1'b0;
          r.click_valid   = 1'b1;
          r.click_pos_x   = ps2mct_pkg::POS_W'(click_x);
          r.click_pos_y   = ps2mct_pkg::POS_W'(click_y);
        end
      end
      default: begin
        cur_x = bound_of(width_reg) / 2;
        cur_y = bound_of(height_reg) / 2;
        gen++;
      end
    endcase
    r.pos_x        = ps2mct_pkg::POS_W'(cur_x);
    r.pos_y        = ps2mct_pkg::POS_W'(cur_y);
    r.left_down    = buttons[ps2mct_pkg::BTN_LEFT];
    r.right_down   = buttons[ps2mct_pkg::BTN_RIGHT];
    r.middle_down  = buttons[ps2mct_pkg::BTN_MIDDLE];
    r.update_count = gen;
    r.wheel_total  = ps2mct_pkg::WHEEL_W'(wheel_seen);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // checking
  // -------------------------------------------------------------------------

  task automatic flag_error(string msg);
    error_count++;
    $display("ERROR: %s", msg);
  endtask

  task automatic compare_result(ps2mct_pkg::out_item_t got, ps2mct_pkg::out_item_t want);
    if (got.pos_x !== want.pos_x)
      flag_error($sformatf("item %0d pos_x %0d, want %0d", checked, got.pos_x, want.pos_x));
    if (got.pos_y !== want.pos_y)
      flag_error($sformatf("item %0d pos_y %0d, want %0d", checked, got.pos_y, want.pos_y));
    if (got.left_down !== want.left_down)
      flag_error($sformatf("item %0d left_down %b, want %b", checked, got.left_down,
                           want.left_down));
    if (got.right_down !== want.right_down)
      flag_error($sformatf("item %0d right_down %b, want %b", checked, got.right_down,
                           want.right_down));
    if (got.middle_down !== want.middle_down)
      flag_error($sformatf("item %0d middle_down %b, want %b", checked, got.middle_down,
                           want.middle_down));
    if (got.update_count !== want.update_count)
      flag_error($sformatf("item %0d update_count %0d, want %0d", checked,
                           got.update_count, want.update_count));
    if (got.wheel_total !== want.wheel_total)
      flag_error($sformatf("item %0d wheel_total %0d, want %0d", checked,
                           $signed(got.wheel_total), $signed(want.wheel_total)));
    if (got.click_valid !== want.click_valid)
      flag_error($sformatf("item %0d click_valid %b, want %b", checked, got.click_valid,
                           want.click_valid));
    if (got.click_pos_x !== want.click_pos_x)
      flag_error($sformatf("item %0d click_pos_x %0d, want %0d", checked, got.click_pos_x,
                           want.click_pos_x));
    if (got.click_pos_y !== want.click_pos_y)
      flag_error($sformatf("item %0d click_pos_y %0d, want %0d", checked, got.click_pos_y,
                           want.click_pos_y));
    if (got.packet_done !== want.packet_done)
      flag_error($sformatf("item %0d packet_done %b, want %b", checked, got.packet_done,
                           want.packet_done));
  endtask

  // -------------------------------------------------------------------------
  // driver: valid held with a stable payload until the block takes the item
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_ring[made[7:0]] <= track_item(in_item);
        made <= made + 1;
      end
      // slot is free when empty or just taken
      if (!in_valid || in_ready_o) begin
        if (queued_items.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
          in_item  <= queued_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // monitor: random back pressure, each taken result against the oldest expectation
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (checked == made) begin
          flag_error("result with no item outstanding");
        end else begin
          compare_result(out_item_o, expected_ring[checked[7:0]]);
          checked <= checked + 1;
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 11);
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers, called from the sequencer on falling edges
  // -------------------------------------------------------------------------

  task automatic push_item(ps2mct_pkg::op_e op, logic [7:0] b);
    ps2mct_pkg::in_item_t it;
    it.op        = op;
    it.data_byte = b;
    queued_items.push_back(it);
  endtask

  // three or four bytes per the current mode; mix drops stray ops between bytes
  task automatic push_packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                             logic [7:0] b3, bit mix);
    logic [7:0] bytes [4];
    int         len;
    bytes = '{b0, b1, b2, b3};
    len   = wheel_on ? 4 : 3;
    for (int i = 0; i < len; i++) begin
      push_item(ps2mct_pkg::OP_DATA, bytes[i]);
      if (mix && i < len - 1 && $urandom_range(9) == 0)
        push_item(ps2mct_pkg::op_e'($urandom_range(1, 3)), 8'($urandom));
    end
  endtask

  // half fully random, half a large step in the drift direction
  function automatic logic [7:0] move_byte();
    logic [7:0] mag;
    if ($urandom_range(1) == 0) return 8'($urandom);
    mag = 8'($urandom_range(96, 127));
    return heading ? mag : (~mag + 8'd1);
  endfunction

  // inputs change on the rising edge only
  task automatic write_reg(ps2mct_pkg::cfg_idx_e idx, logic [ps2mct_pkg::BOUND_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      ps2mct_pkg::CFG_WIDTH:  if (val != 0) width_reg = 32'(val);
      ps2mct_pkg::CFG_HEIGHT: if (val != 0) height_reg = 32'(val);
      ps2mct_pkg::CFG_WHEEL:  wheel_on = val[0];
      default:    ;
    endcase
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // sender holds off until every queued item has its result
  task automatic drain();
    while (queued_items.size() != 0 || in_valid || made != checked) @(negedge clk_i);
  endtask

  // mostly well formed packets, the rest noise, truncated packets and other ops
  task automatic random_traffic(int n);
    int pushed;
    int pick;
    pushed = 0;
    while (pushed < n) begin
      pick = $urandom_range(99);
      if ($urandom_range(39) == 0) heading = !heading;
      if (pick < 70) begin
        push_packet(8'($urandom) | 8'h08, move_byte(), move_byte(), 8'($urandom), 1'b1);
        pushed += wheel_on ? 4 : 3;
      end else if (pick < 78) begin
        // sync bit clear, dropped when it lands on a packet start
        push_item(ps2mct_pkg::OP_DATA, 8'($urandom) & 8'hF7);
      end else if (pick < 84) begin
        // packet head cut short, later bytes fall out of alignment
        push_item(ps2mct_pkg::OP_DATA, 8'($urandom) | 8'h08);
        push_item(ps2mct_pkg::OP_DATA, move_byte());
        pushed += 2;
      end else begin
        push_item(ps2mct_pkg::op_e'($urandom_range(1, 3)), 8'($urandom));
        pushed++;
      end
    end
  endtask

  // a run of same-sign wheel steps, then read the total out
  task automatic wheel_sweep(int packets, logic [3:0] nib);
    for (int k = 0; k < packets; k++) begin
      if ($urandom_range(39) == 0) heading = !heading;
      push_packet(8'($urandom) | 8'h08, move_byte(), move_byte(), {4'($urandom), nib}, 1'b0);
    end
    push_item(ps2mct_pkg::OP_WHEEL, 8'($urandom));
  endtask

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  initial begin : sequencer
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, three-byte packets
    push_item(ps2mct_pkg::OP_DATA, 8'h00);          // out of sync, dropped
    push_item(ps2mct_pkg::OP_DATA, 8'hF7);          // every bit but sync set, dropped
    push_packet(8'h09, 8'h7F, 8'h80, 8'h00, 1'b0);  // left down, full right, y clamps
    push_packet(8'h08, 8'h80, 8'h7F, 8'h00, 1'b0);  // left release latches a click
    push_item(ps2mct_pkg::OP_CLICK, 8'hFF);
    push_item(ps2mct_pkg::OP_CLICK, 8'h00);         // nothing pending any more
    push_item(ps2mct_pkg::OP_WHEEL, 8'h00);
    push_item(ps2mct_pkg::OP_RECENTER, 8'hFF);
    push_packet(8'hFF, 8'hFF, 8'h01, 8'h00, 1'b0);  // all buttons, upper bits set
    drain();

    // zero bounds are ignored, unused index is ignored
    write_reg(ps2mct_pkg::CFG_WIDTH, '0);
    write_reg(ps2mct_pkg::CFG_HEIGHT, '0);
    write_reg(ps2mct_pkg::CFG_NONE, '1);
    write_reg(ps2mct_pkg::CFG_WHEEL, 13'd1);
    push_packet(8'h08, 8'h01, 8'hFF, 8'h07, 1'b0);  // wheel +7
    push_packet(8'h08, 8'h00, 8'h00, 8'hF8, 1'b0);  // wheel -8
    push_item(ps2mct_pkg::OP_DATA, 8'h0B);          // three bytes of a four-byte packet
    push_item(ps2mct_pkg::OP_DATA, 8'h10);
    push_item(ps2mct_pkg::OP_DATA, 8'hF0);
    drain();

    // drop to three-byte mode with three bytes held: next byte completes it
    write_reg(ps2mct_pkg::CFG_WHEEL, 13'd0);
    push_item(ps2mct_pkg::OP_DATA, 8'h5A);
    push_item(ps2mct_pkg::OP_DATA, 8'h0C);
    push_item(ps2mct_pkg::OP_DATA, 8'h05);
    drain();

    // back to wheel mode with two bytes held: needs two more
    write_reg(ps2mct_pkg::CFG_WHEEL, 13'd1);
    push_item(ps2mct_pkg::OP_DATA, 8'h03);
    push_item(ps2mct_pkg::OP_DATA, 8'hF0);          // wheel nibble zero, no step
    drain();

    // bounds past the coordinate range, then the smallest bounds
    write_reg(ps2mct_pkg::CFG_WIDTH, '1);
    write_reg(ps2mct_pkg::CFG_HEIGHT, '1);
    push_item(ps2mct_pkg::OP_RECENTER, 8'h00);
    drain();
    write_reg(ps2mct_pkg::CFG_WIDTH, 13'd1);
    write_reg(ps2mct_pkg::CFG_HEIGHT, 13'd1);
    push_item(ps2mct_pkg::OP_RECENTER, 8'h00);
    drain();

    // same-sign wheel runs both ways at the widest bounds
    write_reg(ps2mct_pkg::CFG_WIDTH, '1);
    write_reg(ps2mct_pkg::CFG_HEIGHT, '1);
    wheel_sweep(40, 4'h7);
    wheel_sweep(40, 4'h8);
    random_traffic(150);
    drain();

    // three-byte packets at the widest bounds
    write_reg(ps2mct_pkg::CFG_WHEEL, 13'd0);
    random_traffic(150);
    drain();

    // long stretch with no idling on either side
    write_reg(ps2mct_pkg::CFG_WIDTH, 13'd4096);
    write_reg(ps2mct_pkg::CFG_HEIGHT, 13'd4096);
    write_reg(ps2mct_pkg::CFG_WHEEL, 13'd1);
    steady = 1'b1;
    random_traffic(300);
    drain();
    steady = 1'b0;

    write_reg(ps2mct_pkg::CFG_WIDTH, 13'(ps2mct_pkg::WIDTH_RST));
    write_reg(ps2mct_pkg::CFG_HEIGHT, 13'(ps2mct_pkg::HEIGHT_RST));
    write_reg(ps2mct_pkg::CFG_WHEEL, 13'd0);
    random_traffic(200);
    drain();

    // assorted settings, small screens or random bounds
    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(3) == 0) write_reg(ps2mct_pkg::CFG_HEIGHT, '0);
      write_reg(ps2mct_pkg::CFG_WIDTH,
                $urandom_range(1) ? 13'($urandom_range(1, 640)) : 13'($urandom));
      write_reg(ps2mct_pkg::CFG_HEIGHT,
                $urandom_range(1) ? 13'($urandom_range(1, 480)) : 13'($urandom));
      write_reg(ps2mct_pkg::CFG_WHEEL, 13'($urandom_range(1)));
      if ($urandom_range(1) == 0) push_item(ps2mct_pkg::OP_RECENTER, 8'($urandom));
      random_traffic(150);
      drain();
    end

    // let anything stray drain out of the pipeline
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #10000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
hdl/ps2mct_pkg.sv
hdl/ps2mct_axis.sv
hdl/ps2_mouse_packet_cursor_tracker.sv
dv/ps2_mouse_packet_cursor_tracker_tb.sv
